>>> sv/utf8v_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
`timescale 1ns / 1ps

package utf8v_pkg;

   // Byte classes as seen by the back end
   typedef enum logic [2:0] {
      CLS_ASCII = 3'd0,
      CLS_LEAD2 = 3'd1,
      CLS_LEAD3 = 3'd2,
      CLS_LEAD4 = 3'd3,
      CLS_CONT  = 3'd4,
      CLS_BAD   = 3'd5
   } byte_class_type;

   // One classified transaction held in the queue
   typedef struct packed {
      logic           end_of_string;
      logic           has_byte;
      byte_class_type cls;
      logic [5:0]     payload;
   } utf8v_item_type;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam int CpW = 21;

   localparam logic [7:0] AsciiMax   = 8'h7f;
   localparam logic [7:0] Lead2Mask  = 8'he0;
   localparam logic [7:0] Lead2Tag   = 8'hc0;
   localparam logic [7:0] Lead3Mask  = 8'hf0;
   localparam logic [7:0] Lead3Tag   = 8'he0;
   localparam logic [7:0] Lead4Mask  = 8'hf8;
   localparam logic [7:0] Lead4Tag   = 8'hf0;
   localparam logic [7:0] ContMask   = 8'hc0;
   localparam logic [7:0] ContTag    = 8'h80;
   localparam logic [7:0] PayloadMsk = 8'h3f;

   localparam logic [CpW-1:0] Min3Byte  = 21'h000800;
   localparam logic [CpW-1:0] Min4Byte  = 21'h010000;
   localparam logic [CpW-1:0] SurrLow   = 21'h00d800;
   localparam logic [CpW-1:0] SurrHigh  = 21'h00dfff;
   localparam logic [CpW-1:0] MaxCodePt = 21'h10ffff;

endpackage

>>> sv/utf8_stream_validator_core.sv
// UTF-8 stream validator: checks a byte string, one verdict per end mark.
//
// Input channel (req_*): one transaction per byte. req_has_byte marks that
// req_data_byte carries a byte; req_end_of_string closes the string, after
// the byte of the same transaction, if any, has been checked.
// Result channel (rsp_*): one transaction per end mark, rsp_string_valid is 1
// when the whole string was well-formed UTF-8. Transactions with neither a
// byte nor an end mark produce nothing.
// Throughput: one transaction per cycle while no stall holds it. The front
// end classifies the byte and writes it into a four-entry queue; the back
// end takes one entry per cycle, except that an end mark waits for room in
// the output register, and it updates the sequence state. An accepted end
// mark is queued, then popped by the back end, which registers the verdict.
// When rsp_stall is high, the verdict holds in the output register; byte
// transactions keep draining, and the queue fills until req_stall rises.
// Reset (synchronous) empties the queue, drops any pending verdict and
// starts a fresh string.
`timescale 1ns / 1ps

module utf8_stream_validator_core
   import utf8v_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_has_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_string_valid
);

   logic           push_valid;
   logic           push_full;
   utf8v_item_type push_item;
   logic           pop_valid;
   logic           pop_take;
   utf8v_item_type pop_item;

   utf8v_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_end_of_string (req_end_of_string),
      .push_valid        (push_valid),
      .push_full         (push_full),
      .push_item         (push_item)
   );

   utf8v_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_item   (pop_item)
   );

   utf8v_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_take         (pop_take),
      .pop_item         (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_string_valid (rsp_string_valid)
   );

endmodule

>>> sv/utf8v_front.sv
// Front end: classifies each incoming byte and pushes it into the queue.
`timescale 1ns / 1ps

module utf8v_front
   import utf8v_pkg::*;
(
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [7:0]     req_data_byte,
   input  logic           req_has_byte,
   input  logic           req_end_of_string,
   output logic           push_valid,
   input  logic           push_full,
   output utf8v_item_type push_item
);

   byte_class_type cls;
   logic [7:0]     pay_mask;

   always_comb begin
      pay_mask = PayloadMsk;
      if (req_data_byte <= AsciiMax) begin
         cls = CLS_ASCII;
      end else if ((req_data_byte & ContMask) == ContTag) begin
         cls = CLS_CONT;
      end else if ((req_data_byte & Lead2Mask) == Lead2Tag) begin
         // C0 and C1 can only start overlong forms
         cls      = (req_data_byte[4:1] == 4'd0) ? CLS_BAD : CLS_LEAD2;
         pay_mask = ~Lead2Mask;
      end else if ((req_data_byte & Lead3Mask) == Lead3Tag) begin
         cls      = CLS_LEAD3;
         pay_mask = ~Lead3Mask;
      end else if ((req_data_byte & Lead4Mask) == Lead4Tag) begin
         cls      = CLS_LEAD4;
         pay_mask = ~Lead4Mask;
      end else begin
         cls = CLS_BAD;
      end
   end

   assign push_item.end_of_string = req_end_of_string;
   assign push_item.has_byte      = req_has_byte;
   assign push_item.cls           = cls;
   assign push_item.payload       = req_data_byte[5:0] & pay_mask[5:0];

   assign push_valid = req_valid;
   assign req_stall  = push_full;

endmodule

>>> sv/utf8v_queue.sv
// Short FIFO of classified transactions between front and back ends.
`timescale 1ns / 1ps

module utf8v_queue
   import utf8v_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_full,
   input  utf8v_item_type push_item,
   output logic           pop_valid,
   input  logic           pop_take,
   output utf8v_item_type pop_item
);

   utf8v_item_type        slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_full = (count_ff == QueueCntW'(QueueDepth));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && !push_full;
   assign do_pop  = pop_valid && pop_take;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/utf8v_back.sv
// Back end: sequence state, code point checks and the registered verdict.
`timescale 1ns / 1ps

module utf8v_back
   import utf8v_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_take,
   input  utf8v_item_type pop_item,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_string_valid
);

   logic [1:0]     pending_ff, pending_in;
   logic [1:0]     seq_len_ff, seq_len_in;
   logic [CpW-1:0] cp_ff, cp_in;
   logic           err_ff, err_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           verdict_ff, verdict_in;

   logic           out_free;
   logic           bad;
   logic [CpW-1:0] cp_next;
   logic [1:0]     pend_next;

   // End marks wait for room in the output register; other transactions never do
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop_take = pop_valid && (!pop_item.end_of_string || out_free);

   always_comb begin
      pending_in   = pending_ff;
      seq_len_in   = seq_len_ff;
      cp_in        = cp_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      verdict_in   = verdict_ff;
      bad          = 1'b0;
      cp_next      = {cp_ff[CpW-7:0], pop_item.payload};
      pend_next    = pending_ff - 2'd1;

      if (pop_take && pop_item.has_byte && !err_ff) begin
         if (pending_ff == 2'd0) begin
            case (pop_item.cls)
               CLS_ASCII: begin
               end
               CLS_LEAD2: begin
                  cp_in      = CpW'(pop_item.payload);
                  pending_in = 2'd1;
                  seq_len_in = 2'd1;
               end
               CLS_LEAD3: begin
                  cp_in      = CpW'(pop_item.payload);
                  pending_in = 2'd2;
                  seq_len_in = 2'd2;
               end
               CLS_LEAD4: begin
                  cp_in      = CpW'(pop_item.payload);
                  pending_in = 2'd3;
                  seq_len_in = 2'd3;
               end
               default: bad = 1'b1;
            endcase
         end else if (pop_item.cls != CLS_CONT) begin
            bad = 1'b1;
         end else begin
            cp_in      = cp_next;
            pending_in = pend_next;
            if (pend_next == 2'd0) begin
               if ((seq_len_ff == 2'd2 && cp_next < Min3Byte) ||
                   (seq_len_ff == 2'd3 && cp_next < Min4Byte) ||
                   (cp_next >= SurrLow && cp_next <= SurrHigh) ||
                   cp_next > MaxCodePt) begin
                  bad = 1'b1;
               end else begin
                  seq_len_in = 2'd0;
                  cp_in      = '0;
               end
            end
         end
         if (bad) begin
            err_in     = 1'b1;
            pending_in = 2'd0;
            seq_len_in = 2'd0;
            cp_in      = '0;
         end
      end

      if (pop_take && pop_item.end_of_string) begin
         rsp_valid_in = 1'b1;
         verdict_in   = !err_in && (pending_in == 2'd0);
         pending_in   = 2'd0;
         seq_len_in   = 2'd0;
         cp_in        = '0;
         err_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         seq_len_ff   <= '0;
         cp_ff        <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         seq_len_ff   <= seq_len_in;
         cp_ff        <= cp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_string_valid = verdict_ff;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the UTF-8 stream validator core.
`timescale 1ns / 1ps

module tb_top;

   localparam int RandomItems = 600;
   localparam int CycleLimit  = 100000;
   localparam int DrainCycles = 10;
   localparam int LongHold    = 120;

   // Keeps its own decoder state, predicts one verdict per end mark and
   // checks the verdicts that come back in order.
   class utf8_verdict_scoreboard;
      bit [1:0]  due;
      bit [1:0]  seq_len;
      bit [20:0] cp_acc;
      bit        broken;
      bit        expected_verdicts[$];
      int        mismatches;

      function void clear_string();
         due     = 2'd0;
         seq_len = 2'd0;
         cp_acc  = 21'd0;
         broken  = 1'b0;
      endfunction

      function void mark_broken();
         clear_string();
         broken = 1'b1;
      endfunction

      function void absorb_byte(bit [7:0] b);
         if (broken)
            return;
         if (due == 2'd0) begin
            if (b <= 8'h7f)
               return;
            if ((b & 8'he0) == 8'hc0) begin
               // C0 and C1 can only encode ASCII
               if (b[4:0] < 5'd2) begin
                  mark_broken();
                  return;
               end
               cp_acc  = {16'd0, b[4:0]};
               due     = 2'd1;
               seq_len = 2'd1;
            end else if ((b & 8'hf0) == 8'he0) begin
               cp_acc  = {17'd0, b[3:0]};
               due     = 2'd2;
               seq_len = 2'd2;
            end else if ((b & 8'hf8) == 8'hf0) begin
               cp_acc  = {18'd0, b[2:0]};
               due     = 2'd3;
               seq_len = 2'd3;
            end else begin
               mark_broken();
            end
            return;
         end
         if ((b & 8'hc0) != 8'h80) begin
            mark_broken();
            return;
         end
         cp_acc = {cp_acc[14:0], b[5:0]};
         due    = due - 2'd1;
         if (due == 2'd0) begin
            if ((seq_len == 2'd2 && cp_acc < 21'h000800) ||
                (seq_len == 2'd3 && cp_acc < 21'h010000) ||
                (cp_acc >= 21'h00d800 && cp_acc <= 21'h00dfff) ||
                cp_acc > 21'h10ffff) begin
               mark_broken();
               return;
            end
            seq_len = 2'd0;
            cp_acc  = 21'd0;
         end
      endfunction

      function void note_request(bit [7:0] b, bit has, bit eos);
         bit verdict;
         if (has)
            absorb_byte(b);
         if (eos) begin
            verdict           = !broken && due == 2'd0;
            expected_verdicts = {expected_verdicts, verdict};
            clear_string();
         end
      endfunction

      function void check_verdict(bit actual);
         bit wanted;
         if (expected_verdicts.size() == 0) begin
            $display("%0t: verdict with none expected, expected none, actual %0b",
                     $time, actual);
            mismatches++;
            return;
         end
         wanted = expected_verdicts.pop_front();
         if (actual !== wanted) begin
            $display("%0t: string_valid mismatch, expected %0b, actual %0b",
                     $time, wanted, actual);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_verdicts.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_has_byte;
   logic       req_end_of_string;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_string_valid;

   utf8_verdict_scoreboard board = new();

   logic [7:0]  string_bytes[$];
   int unsigned items_sent;
   int unsigned cycle_count;
   int unsigned long_hold_cycles;
   bit          steady_flow;

   utf8_stream_validator_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_string_valid  (rsp_string_valid)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // Both channels are observed at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(req_data_byte, req_has_byte, req_end_of_string);
         if (rsp_valid && !rsp_stall)
            board.check_verdict(rsp_string_valid);
      end
   end

   // Result side: random stall before each verdict outside steady flow, plus one long hold on request
   initial begin
      int unsigned hold;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            hold             = long_hold_cycles;
            long_hold_cycles = 0;
         end else begin
            hold = steady_flow ? 0 : $urandom_range(0, 4);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(logic [7:0] b, logic has, logic eos);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_has_byte      <= has;
      req_end_of_string <= eos;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (has || eos)
         items_sent++;
   endtask

   task automatic send_string(bit end_alone);
      int n;
      n = string_bytes.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(string_bytes[i], 1'b1, (i == n - 1) && !end_alone);
      end
      if (end_alone || n == 0)
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   function automatic void append_byte(logic [7:0] b);
      string_bytes = {string_bytes, b};
   endfunction

   function automatic int unsigned natural_len(bit [20:0] cp);
      if (cp < 21'h80)
         return 1;
      if (cp < 21'h800)
         return 2;
      if (cp < 21'h10000)
         return 3;
      return 4;
   endfunction

   // Encodes cp in len bytes, whether or not that length is legal for it
   function automatic void append_char(bit [20:0] cp, int unsigned len);
      case (len)
         1: append_byte({1'b0, cp[6:0]});
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic void append_random_char();
      bit [20:0]   boundaries[9];
      bit [20:0]   cp;
      int unsigned pick;
      int unsigned len;
      boundaries = '{21'h7f, 21'h80, 21'h7ff, 21'h800, 21'hd7ff, 21'he000,
                     21'hffff, 21'h10000, 21'h10ffff};
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         cp = boundaries[$urandom_range(0, 8)];
         append_char(cp, natural_len(cp));
      end else if (pick < 35) begin
         append_char(21'($urandom_range(0, 21'h7f)), 1);
      end else if (pick < 55) begin
         append_char(21'($urandom_range(21'h80, 21'h7ff)), 2);
      end else if (pick < 72) begin
         cp = 21'($urandom_range(21'h800, 21'hffff));
         if (cp >= 21'hd800 && cp <= 21'hdfff)
            cp[12] = 1'b0;
         append_char(cp, 3);
      end else if (pick < 88) begin
         append_char(21'($urandom_range(21'h10000, 21'h10ffff)), 4);
      end else if (pick < 91) begin
         // overlong: a shorter form exists
         len = $urandom_range(2, 4);
         case (len)
            2: append_char(21'($urandom_range(0, 21'h7f)), 2);
            3: append_char(21'($urandom_range(0, 21'h7ff)), 3);
            default: append_char(21'($urandom_range(0, 21'hffff)), 4);
         endcase
      end else if (pick < 94) begin
         append_char(21'($urandom_range(21'hd800, 21'hdfff)), 3);
      end else if (pick < 97) begin
         append_char(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
      end else begin
         append_byte(8'($urandom));
      end
   endfunction

   function automatic void build_random_string();
      int unsigned kind;
      int unsigned chars;
      kind  = $urandom_range(0, 11);
      chars = $urandom_range(0, 5);
      string_bytes.delete();
      if (kind == 0) begin
         repeat (chars + 1) append_byte(8'($urandom));
      end else begin
         repeat (chars) append_random_char();
         if (kind == 1 && string_bytes.size() > 0)
            void'(string_bytes.pop_back());
         else if (kind == 2 && string_bytes.size() > 0)
            string_bytes[$urandom_range(0, string_bytes.size() - 1)] = 8'($urandom);
      end
   endfunction

   initial begin
      int unsigned strings_done;
      bit          pressure_done;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_data_byte     <= 8'h00;
      req_has_byte      <= 1'b0;
      req_end_of_string <= 1'b0;
      cycle_count       = 0;
      items_sent        = 0;
      long_hold_cycles  = 0;
      steady_flow       = 1'b0;
      strings_done      = 0;
      pressure_done     = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed strings
      string_bytes.delete();
      send_string(1'b1);                        // empty string
      string_bytes = '{8'h00};
      send_string(1'b0);
      string_bytes = '{8'hff};
      send_string(1'b0);
      string_bytes = '{8'h80, 8'h41};           // stray continuation, then ignored byte
      send_string(1'b0);
      string_bytes = '{8'hc1};
      send_string(1'b0);
      string_bytes = '{8'hc2, 8'h80};
      send_string(1'b0);
      send_item(8'ha5, 1'b0, 1'b0);             // neither byte nor end mark
      string_bytes = '{8'hed, 8'ha0, 8'h80};    // surrogate
      send_string(1'b0);
      string_bytes = '{8'he0, 8'h80, 8'h80};    // 3-byte overlong
      send_string(1'b0);
      string_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};
      send_string(1'b0);
      string_bytes = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
      send_string(1'b0);
      string_bytes = '{8'he2, 8'h82};           // still open at end mark
      send_string(1'b1);
      string_bytes = '{8'hc2, 8'h41};
      send_string(1'b0);

      while (items_sent < RandomItems + 28) begin
         strings_done++;
         steady_flow = ((strings_done / 16) % 4 == 3);
         if (!pressure_done && items_sent > 300) begin
            // hold off the result side and keep sending short strings
            pressure_done    = 1'b1;
            steady_flow      = 1'b1;
            long_hold_cycles = LongHold;
            repeat (24) begin
               string_bytes.delete();
               append_byte(8'($urandom_range(0, 8'h7f)));
               send_string(1'b0);
            end
         end
         build_random_string();
         send_string($urandom_range(0, 3) == 0);
      end

      req_valid <= 1'b0;
      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
sv/utf8v_pkg.sv
sv/utf8v_front.sv
sv/utf8v_queue.sv
sv/utf8v_back.sv
sv/utf8_stream_validator_core.sv
tb/sv/tb_top.sv
